@@ src/mobius_inverse_remap_assert.svh @@
// assertion macros shared by the remap checker
`ifndef MOBIUS_INVERSE_REMAP_ASSERT_SVH
`define MOBIUS_INVERSE_REMAP_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define MIR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("remap check failed");

// consequent must hold a fixed number of cycles after the antecedent
`define MIR_ASSERT_LATER(label, clk, rst_n, ante, n, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##n (cons)) \
    else $error("remap check failed");

`endif

@@ src/mir_pkg.sv @@
// types and constants of the mobius inverse remap block
`default_nettype none
package mir_pkg;

  localparam int FW   = 10;   // pixel coordinate field width
  localparam int CW   = 32;   // coefficient width, q16.16
  localparam int ZW   = 14;   // doubled centred coordinate, signed
  localparam int NW   = 46;   // numerator and denominator, signed q.17
  localparam int MAGW = 45;   // magnitude of those
  localparam int LOW  = 23;   // low half of a magnitude
  localparam int HIW  = MAGW - LOW;
  localparam int PW   = 2 * MAGW;  // product magnitude
  localparam int SW   = PW + 2;    // signed product sums
  localparam int TW   = 106;       // range test and division width
  localparam int IDXW = 3;

  localparam logic [IDXW-1:0] REG_A_RE = 3'd0;
  localparam logic [IDXW-1:0] REG_A_IM = 3'd1;
  localparam logic [IDXW-1:0] REG_B_RE = 3'd2;
  localparam logic [IDXW-1:0] REG_B_IM = 3'd3;
  localparam logic [IDXW-1:0] REG_C_RE = 3'd4;
  localparam logic [IDXW-1:0] REG_C_IM = 3'd5;
  localparam logic [IDXW-1:0] REG_D_RE = 3'd6;
  localparam logic [IDXW-1:0] REG_D_IM = 3'd7;

  localparam logic [CW-1:0] COEF_ONE  = 32'h0001_0000;
  localparam logic [CW-1:0] COEF_ZERO = 32'h0000_0000;

  typedef struct packed {
    logic [FW-1:0] pixel_col;
    logic [FW-1:0] pixel_row;
  } in_word_t;

  typedef struct packed {
    logic [FW-1:0] source_col;
    logic          col_valid;
    logic [FW-1:0] source_row;
    logic          row_valid;
  } out_word_t;

  typedef struct packed {
    logic [CW-1:0] a_re;
    logic [CW-1:0] a_im;
    logic [CW-1:0] b_re;
    logic [CW-1:0] b_im;
    logic [CW-1:0] c_re;
    logic [CW-1:0] c_im;
    logic [CW-1:0] d_re;
    logic [CW-1:0] d_im;
  } coef_t;

  typedef struct packed {
    logic            valid;
    logic            zero;
    logic [MAGW-1:0] nre;
    logic [MAGW-1:0] nim;
    logic [MAGW-1:0] mre;
    logic [MAGW-1:0] mim;
    logic            s_nre;
    logic            s_nim;
    logic            s_mre;
    logic            s_mim;
  } front_t;

  typedef struct packed {
    logic          valid;
    logic          ok;
    logic [FW-1:0] coord;
  } place_t;

endpackage
`default_nettype wire

@@ src/mir_front.sv @@
// centring, coefficient products and numerator/denominator forming
`default_nettype none
module mir_front #(
  parameter int IMAGE_WIDTH  = 1024,
  parameter int IMAGE_HEIGHT = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  mir_pkg::in_word_t in_word,
  input  mir_pkg::coef_t   coef,
  output mir_pkg::front_t  res
);
  import mir_pkg::*;

  localparam logic signed [ZW-1:0] W_S = ZW'(IMAGE_WIDTH);
  localparam logic signed [ZW-1:0] H_S = ZW'(IMAGE_HEIGHT);

  logic                 v1_r, v2_r, v3_r;
  logic signed [ZW-1:0] zr_r, zi_r;
  logic signed [NW-1:0] dre_zr_r, dim_zi_r, dre_zi_r, dim_zr_r;
  logic signed [NW-1:0] cre_zr_r, cim_zi_r, cre_zi_r, cim_zr_r;
  logic signed [NW-1:0] nre_r, nim_r, mre_r, mim_r;
  logic signed [NW-1:0] abs_nre, abs_nim, abs_mre, abs_mim;
  front_t               res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // z held in half units
  always_ff @(posedge clk) begin
    zr_r <= $signed({3'b000, in_word.pixel_col, 1'b0}) - W_S;
    zi_r <= H_S - $signed({3'b000, in_word.pixel_row, 1'b0});
  end

  always_ff @(posedge clk) begin
    dre_zr_r <= $signed(coef.d_re) * zr_r;
    dim_zi_r <= $signed(coef.d_im) * zi_r;
    dre_zi_r <= $signed(coef.d_re) * zi_r;
    dim_zr_r <= $signed(coef.d_im) * zr_r;
    cre_zr_r <= $signed(coef.c_re) * zr_r;
    cim_zi_r <= $signed(coef.c_im) * zi_r;
    cre_zi_r <= $signed(coef.c_re) * zi_r;
    cim_zr_r <= $signed(coef.c_im) * zr_r;
  end

  always_ff @(posedge clk) begin
    nre_r <= dre_zr_r - dim_zi_r - (NW'($signed(coef.b_re)) <<< 1);
    nim_r <= dre_zi_r + dim_zr_r - (NW'($signed(coef.b_im)) <<< 1);
    mre_r <= (NW'($signed(coef.a_re)) <<< 1) - (cre_zr_r - cim_zi_r);
    mim_r <= (NW'($signed(coef.a_im)) <<< 1) - (cre_zi_r + cim_zr_r);
  end

  assign abs_nre = nre_r[NW-1] ? -nre_r : nre_r;
  assign abs_nim = nim_r[NW-1] ? -nim_r : nim_r;
  assign abs_mre = mre_r[NW-1] ? -mre_r : mre_r;
  assign abs_mim = mim_r[NW-1] ? -mim_r : mim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r.valid <= 1'b0;
    end else begin
      res_r.valid <= v3_r;
    end
    res_r.zero  <= (mre_r == '0) && (mim_r == '0);
    res_r.nre   <= abs_nre[MAGW-1:0];
    res_r.nim   <= abs_nim[MAGW-1:0];
    res_r.mre   <= abs_mre[MAGW-1:0];
    res_r.mim   <= abs_mim[MAGW-1:0];
    res_r.s_nre <= nre_r[NW-1];
    res_r.s_nim <= nim_r[NW-1];
    res_r.s_mre <= mre_r[NW-1];
    res_r.s_mim <= mim_r[NW-1];
  end

  assign res = res_r;

endmodule
`default_nettype wire

@@ src/mir_wmul.sv @@
// three stage signed multiplier built from four half-width partial products
`default_nettype none
module mir_wmul (
  input  logic                          clk,
  input  logic [mir_pkg::MAGW-1:0]      a,
  input  logic [mir_pkg::MAGW-1:0]      b,
  input  logic                          neg,
  output logic signed [mir_pkg::SW-1:0] prod
);
  import mir_pkg::*;

  logic [2*LOW-1:0]   ll_r;
  logic [LOW+HIW-1:0] lh_r, hl_r;
  logic [2*HIW-1:0]   hh_r;
  logic               n1_r, n2_r;
  logic [PW-1:0]      sum_r;
  logic signed [SW-1:0] prod_r;

  always_ff @(posedge clk) begin
    ll_r <= a[LOW-1:0] * b[LOW-1:0];
    lh_r <= a[LOW-1:0] * b[MAGW-1:LOW];
    hl_r <= a[MAGW-1:LOW] * b[LOW-1:0];
    hh_r <= a[MAGW-1:LOW] * b[MAGW-1:LOW];
    n1_r <= neg;
  end

  always_ff @(posedge clk) begin
    sum_r <= PW'(ll_r) + (PW'(lh_r) << LOW) + (PW'(hl_r) << LOW) + (PW'(hh_r) << (2 * LOW));
    n2_r  <= n1_r;
  end

  always_ff @(posedge clk) begin
    prod_r <= n2_r ? -$signed(SW'(sum_r)) : $signed(SW'(sum_r));
  end

  assign prod = prod_r;

endmodule
`default_nettype wire

@@ src/mir_place.sv @@
// range test and restoring division giving one source coordinate
`default_nettype none
module mir_place #(
  parameter int SIZE = 1024,
  parameter int QW   = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_zero,
  input  logic signed [mir_pkg::SW-1:0] q,
  input  logic signed [mir_pkg::SW-1:0] v,
  output mir_pkg::place_t               res
);
  import mir_pkg::*;

  logic                 v1_r, v2_r;
  logic                 z1_r, z2_r;
  logic [TW-1:0]        sq_r, d1_r, d2_r, lim_r;
  logic signed [TW-1:0] v2x_r, t_r;

  logic          vs_r  [QW+1];
  logic          ok_r  [QW+1];
  logic [TW-1:0] rem_r [QW+1];
  logic [TW-1:0] dv_r  [QW+1];
  logic [QW-1:0] quo_r [QW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      vs_r[0]  <= 1'b0;
    end else begin
      v1_r     <= in_valid;
      v2_r     <= v1_r;
      vs_r[0]  <= v2_r;
    end
  end

  // size times q, doubled value
  always_ff @(posedge clk) begin
    sq_r  <= TW'(q) * TW'(SIZE);
    v2x_r <= TW'(v) <<< 1;
    d1_r  <= TW'(q) << 1;
    z1_r  <= in_zero;
  end

  always_ff @(posedge clk) begin
    t_r   <= $signed(sq_r) + v2x_r;
    lim_r <= sq_r << 1;
    d2_r  <= d1_r;
    z2_r  <= z1_r;
  end

  // inside the image when 0 < t < 2 size q
  always_ff @(posedge clk) begin
    ok_r[0]  <= !z2_r && (t_r > 0) && ($signed(lim_r) > t_r);
    rem_r[0] <= t_r;
    dv_r[0]  <= d2_r;
    quo_r[0] <= '0;
  end

  for (genvar i = 0; i < QW; i++) begin : g_div
    logic [TW-1:0] trial;
    logic          ge;
    assign trial = dv_r[i] << (QW - 1 - i);
    assign ge    = rem_r[i] >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vs_r[i+1] <= 1'b0;
      end else begin
        vs_r[i+1] <= vs_r[i];
      end
    end

    always_ff @(posedge clk) begin
      ok_r[i+1]  <= ok_r[i];
      dv_r[i+1]  <= dv_r[i];
      rem_r[i+1] <= ge ? rem_r[i] - trial : rem_r[i];
      quo_r[i+1] <= (quo_r[i] << 1) | QW'(ge);
    end
  end

  assign res.valid = vs_r[QW];
  assign res.ok    = ok_r[QW];
  assign res.coord = ok_r[QW] ? FW'(quo_r[QW]) : '0;

endmodule
`default_nettype wire

@@ src/mobius_inverse_remap.sv @@
// top level of the mobius inverse remap block
//
// maps an output pixel (column, row) to the source pixel it is read from,
// using the inverse mobius map w = (d z - b) / (a - c z) with coefficients
// held in eight q16.16 registers (a, b, c, d, real then imaginary part)
//
// input: a word is taken at each rising edge where start is high and busy
// is low; busy stays low, so one word may enter on every clock
// output: each result is shown for exactly one cycle with out_valid high;
// the receiver cannot stall, so there is no back-pressure anywhere
// division: a restoring divider, one quotient bit per stage, behind the
// three stage wide multipliers
// throughput: one word per clock, results in input order
// configuration: cfg_we writes cfg_data to register cfg_index; the user must
// write only while no word is in flight, the block does not enforce it
// reset: synchronous, clears every valid bit in the pipe and loads a = d = 1,
// b = c = 0 (identity map)
`default_nettype none
module mobius_inverse_remap #(
  parameter int IMAGE_WIDTH  = 1024,
  parameter int IMAGE_HEIGHT = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  mir_pkg::in_word_t          in_word,
  output logic                       out_valid,
  output mir_pkg::out_word_t         out_word,
  input  logic                       cfg_we,
  input  logic [mir_pkg::IDXW-1:0]   cfg_index,
  input  logic [mir_pkg::CW-1:0]     cfg_data
);
  import mir_pkg::*;

  // quotient bits needed for the larger dimension
  localparam int QW = $clog2((IMAGE_WIDTH > IMAGE_HEIGHT) ? IMAGE_WIDTH : IMAGE_HEIGHT);
  localparam int LATENCY = 12 + QW;

  // coefficient registers
  coef_t coef_r, coef_nxt;

  always_comb begin
    coef_nxt = coef_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_A_RE: coef_nxt.a_re = cfg_data;
        REG_A_IM: coef_nxt.a_im = cfg_data;
        REG_B_RE: coef_nxt.b_re = cfg_data;
        REG_B_IM: coef_nxt.b_im = cfg_data;
        REG_C_RE: coef_nxt.c_re = cfg_data;
        REG_C_IM: coef_nxt.c_im = cfg_data;
        REG_D_RE: coef_nxt.d_re = cfg_data;
        REG_D_IM: coef_nxt.d_im = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '{a_re: COEF_ONE,  a_im: COEF_ZERO, b_re: COEF_ZERO, b_im: COEF_ZERO,
                  c_re: COEF_ZERO, c_im: COEF_ZERO, d_re: COEF_ONE,  d_im: COEF_ZERO};
    end else begin
      coef_r <= coef_nxt;
    end
  end

  // fully pipelined, never refuses a word
  assign busy = 1'b0;

  // centring and numerator / denominator, four stages
  front_t fr;

  mir_front #(
    .IMAGE_WIDTH  (IMAGE_WIDTH),
    .IMAGE_HEIGHT (IMAGE_HEIGHT)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(start && !busy),
    .in_word (in_word),
    .coef    (coef_r),
    .res     (fr)
  );

  // six wide products: |m|^2 terms, and the cross terms of n times conj(m)
  logic signed [SW-1:0] pr_mm_re, pr_mm_im, pr_nr_mr, pr_ni_mi, pr_ni_mr, pr_nr_mi;

  mir_wmul u_mul_mre (.clk(clk), .a(fr.mre), .b(fr.mre), .neg(1'b0), .prod(pr_mm_re));
  mir_wmul u_mul_mim (.clk(clk), .a(fr.mim), .b(fr.mim), .neg(1'b0), .prod(pr_mm_im));
  mir_wmul u_mul_pr  (.clk(clk), .a(fr.nre), .b(fr.mre), .neg(fr.s_nre ^ fr.s_mre),
                      .prod(pr_nr_mr));
  mir_wmul u_mul_pi  (.clk(clk), .a(fr.nim), .b(fr.mim), .neg(fr.s_nim ^ fr.s_mim),
                      .prod(pr_ni_mi));
  mir_wmul u_mul_rr  (.clk(clk), .a(fr.nim), .b(fr.mre), .neg(fr.s_nim ^ fr.s_mre),
                      .prod(pr_ni_mr));
  mir_wmul u_mul_ri  (.clk(clk), .a(fr.nre), .b(fr.mim), .neg(fr.s_nre ^ fr.s_mim),
                      .prod(pr_nr_mi));

  // valid and zero-denominator flag follow the multipliers
  logic [2:0] mv_r;
  logic [2:0] mz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r <= '0;
    end else begin
      mv_r <= {mv_r[1:0], fr.valid};
    end
  end

  always_ff @(posedge clk) begin
    mz_r <= {mz_r[1:0], fr.zero};
  end

  // q = |m|^2, p = re(n conj m), rn = -im(n conj m)
  logic                 sv_r, sz_r;
  logic signed [SW-1:0] q_r, p_r, rn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r <= 1'b0;
    end else begin
      sv_r <= mv_r[2];
    end
  end

  always_ff @(posedge clk) begin
    sz_r <= mz_r[2];
    q_r  <= pr_mm_re + pr_mm_im;
    p_r  <= pr_nr_mr + pr_ni_mi;
    rn_r <= pr_nr_mi - pr_ni_mr;
  end

  // range test and division, column and row side by side
  place_t col_res, row_res;

  mir_place #(.SIZE(IMAGE_WIDTH), .QW(QW)) u_place_col (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(sv_r),
    .in_zero (sz_r),
    .q       (q_r),
    .v       (p_r),
    .res     (col_res)
  );

  mir_place #(.SIZE(IMAGE_HEIGHT), .QW(QW)) u_place_row (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(sv_r),
    .in_zero (sz_r),
    .q       (q_r),
    .v       (rn_r),
    .res     (row_res)
  );

  // output register, both halves leave together
  logic      out_valid_r;
  out_word_t out_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= col_res.valid && row_res.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r.source_col <= col_res.coord;
    out_word_r.col_valid  <= col_res.ok;
    out_word_r.source_row <= row_res.coord;
    out_word_r.row_valid  <= row_res.ok;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
`default_nettype wire

@@ src/mir_check.sv @@
// port level checker for the remap block, with its bind
`default_nettype none
`include "mobius_inverse_remap_assert.svh"
module mir_check #(
  parameter int LAT = 22
) (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input mir_pkg::out_word_t out_word
);

  // the block never refuses a word
  `MIR_ASSERT_IMPLY(a_never_busy, clk, rst_n, 1'b1, !busy)

  // every accepted word gives a result after the fixed latency
  `MIR_ASSERT_LATER(a_word_out, clk, rst_n, start && !busy, LAT, out_valid)

  // no result without a word accepted the latency before
  `MIR_ASSERT_IMPLY(a_no_phantom, clk, rst_n, out_valid, $past(start && !busy, LAT))

  // an outside column reads as zero, and so does the row when it is outside too
  `MIR_ASSERT_IMPLY(a_col_zero, clk, rst_n, out_valid && !out_word.col_valid,
                    out_word.source_col == '0 && (out_word.row_valid || out_word.source_row == '0))

endmodule

bind mobius_inverse_remap mir_check #(.LAT(LATENCY)) u_mir_check (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .out_valid(out_valid),
  .out_word (out_word)
);
`default_nettype wire

@@ tb/mir_scoreboard.sv @@
// checker for the mobius inverse remap: tracks coefficients, predicts and compares results
module mir_scoreboard
  import mir_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic            busy,
  input  in_word_t        in_word,
  input  logic            out_valid,
  input  out_word_t       out_word,
  input  logic            cfg_we,
  input  logic [IDXW-1:0] cfg_index,
  input  logic [CW-1:0]   cfg_data,
  output int              fails,
  output int              pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IMG_W = 1024;
  localparam int IMG_H = 1024;

  typedef logic signed [127:0] wide_t;

  coef_t     coefs;
  out_word_t source_queue[$];

  assign pending = source_queue.size();

  task automatic report_mismatch(string what, int exp_v, int got_v);
    $display("mismatch %s: expected %0d got %0d at %0t", what, exp_v, got_v, $realtime);
    fails++;
  endtask

  // floor(size/2 + v/q) with v = two_v/2, valid strictly inside the image
  function automatic void place_axis(wide_t two_v, wide_t q, int size,
                                     output logic [FW-1:0] coord, output logic ok);
    wide_t sq, t;
    sq = q * wide_t'(size);
    t  = sq + two_v;
    coord = '0;
    ok = 1'b0;
    if (t > 0 && t < 2 * sq) begin
      coord = FW'(t / (2 * q));
      ok = 1'b1;
    end
  endfunction

  function automatic out_word_t remap_pixel(in_word_t w, coef_t k);
    longint zr, zi, nre, nim, mre, mim;
    wide_t q, p, r;
    out_word_t res;
    zr  = 2 * longint'(w.pixel_col) - IMG_W;
    zi  = IMG_H - 2 * longint'(w.pixel_row);
    nre = longint'($signed(k.d_re)) * zr - longint'($signed(k.d_im)) * zi
          - 2 * longint'($signed(k.b_re));
    nim = longint'($signed(k.d_re)) * zi + longint'($signed(k.d_im)) * zr
          - 2 * longint'($signed(k.b_im));
    mre = 2 * longint'($signed(k.a_re))
          - (longint'($signed(k.c_re)) * zr - longint'($signed(k.c_im)) * zi);
    mim = 2 * longint'($signed(k.a_im))
          - (longint'($signed(k.c_re)) * zi + longint'($signed(k.c_im)) * zr);
    q = wide_t'(mre) * wide_t'(mre) + wide_t'(mim) * wide_t'(mim);
    p = wide_t'(nre) * wide_t'(mre) + wide_t'(nim) * wide_t'(mim);
    r = wide_t'(nim) * wide_t'(mre) - wide_t'(nre) * wide_t'(mim);
    res = '0;
    if (mre != 0 || mim != 0) begin
      place_axis(2 * p, q, IMG_W, res.source_col, res.col_valid);
      place_axis(-2 * r, q, IMG_H, res.source_row, res.row_valid);
    end
    return res;
  endfunction

  initial fails = 0;

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      coefs = {COEF_ONE, COEF_ZERO, COEF_ZERO, COEF_ZERO,
               COEF_ZERO, COEF_ZERO, COEF_ONE, COEF_ZERO};
      source_queue.delete();
    end else begin
      if (out_valid) begin
        if (source_queue.size() == 0) begin
          report_mismatch("result words outstanding", 0, 1);
        end else begin
          want = source_queue.pop_front();
          if (out_word.source_col != want.source_col)
            report_mismatch("source_col", want.source_col, out_word.source_col);
          if (out_word.col_valid != want.col_valid)
            report_mismatch("col_valid", want.col_valid, out_word.col_valid);
          if (out_word.source_row != want.source_row)
            report_mismatch("source_row", want.source_row, out_word.source_row);
          if (out_word.row_valid != want.row_valid)
            report_mismatch("row_valid", want.row_valid, out_word.row_valid);
        end
      end
      if (start && !busy)
        source_queue.push_back(remap_pixel(in_word, coefs));
      if (cfg_we) begin
        case (cfg_index)
          REG_A_RE: coefs.a_re = cfg_data;
          REG_A_IM: coefs.a_im = cfg_data;
          REG_B_RE: coefs.b_re = cfg_data;
          REG_B_IM: coefs.b_im = cfg_data;
          REG_C_RE: coefs.c_re = cfg_data;
          REG_C_IM: coefs.c_im = cfg_data;
          REG_D_RE: coefs.d_re = cfg_data;
          REG_D_IM: coefs.d_im = cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

@@ tb/tb_top.sv @@
// testbench top for the mobius inverse remap: stimulus, coefficient phases and verdict
module tb_top;
  import mir_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 22;        // pipeline depth at the 1024 square
  localparam int LIMIT   = 200000;    // cycle budget, far above a slow clean run

  logic            clk;
  logic            rst_n;
  logic            start;
  logic            busy;
  in_word_t        in_word;
  logic            out_valid;
  out_word_t       out_word;
  logic            cfg_we;
  logic [IDXW-1:0] cfg_index;
  logic [CW-1:0]   cfg_data;
  int              fails;
  int              pending;
  int              cycles;
  int              words_sent;
  int              coef_sets;
  bit              idle_on;

  mobius_inverse_remap u_top (
    .clk, .rst_n, .start, .busy, .in_word, .out_valid, .out_word,
    .cfg_we, .cfg_index, .cfg_data
  );

  mir_scoreboard u_scoreboard (
    .clk, .rst_n, .start, .busy, .in_word, .out_valid, .out_word,
    .cfg_we, .cfg_index, .cfg_data, .fails, .pending
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("[mobius_inverse_remap] ERROR");
      $finish;
    end
  end

  // offer one pixel word; start stays high afterwards unless a gap is taken next time
  task automatic send_pixel(logic [FW-1:0] col, logic [FW-1:0] row);
    bit taken;
    if (idle_on && $urandom_range(99) < 28) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start   <= 1'b1;
    in_word <= '{pixel_col: col, pixel_row: row};
    do begin
      @(negedge clk);
      taken = !busy;   // busy is settled mid-cycle
      @(posedge clk);
    end while (!taken);
    words_sent++;
  endtask

  // stop sending and let the pipe empty completely
  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  // load all eight coefficients back to back, only with the pipe empty
  task automatic load_coefs(coef_t k);
    logic [CW-1:0] vals[8];
    vals = '{k.a_re, k.a_im, k.b_re, k.b_im, k.c_re, k.c_im, k.d_re, k.d_im};
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= IDXW'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
    coef_sets++;
  endtask

  // near-identity maps: mild rotation and scale, some translation, small pole term
  function automatic coef_t warp_coefs();
    coef_t k;
    k.a_re = CW'(65536 + int'($urandom_range(0, 65536)) - 32768);
    k.a_im = CW'(int'($urandom_range(0, 32768)) - 16384);
    k.b_re = CW'((int'($urandom_range(0, 600)) - 300) * 65536 + int'($urandom_range(0, 65535)));
    k.b_im = CW'((int'($urandom_range(0, 600)) - 300) * 65536 + int'($urandom_range(0, 65535)));
    k.c_re = CW'(int'($urandom_range(0, 512)) - 256);
    k.c_im = CW'(int'($urandom_range(0, 512)) - 256);
    k.d_re = CW'(65536 + int'($urandom_range(0, 65536)) - 32768);
    k.d_im = CW'(int'($urandom_range(0, 32768)) - 16384);
    return k;
  endfunction

  function automatic coef_t wild_coefs();
    coef_t k;
    k = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return k;
  endfunction

  initial begin
    coef_t k;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_word    = '0;
    cfg_we     = 1'b0;
    cfg_index  = REG_A_RE;
    cfg_data   = '0;
    cycles     = 0;
    words_sent = 0;
    coef_sets  = 0;
    idle_on    = 1'b1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset coefficients give the identity map; corners hit the exact image edge
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd0, 10'd1023);
    send_pixel(10'd1023, 10'd0);
    send_pixel(10'd512, 10'd512);
    send_pixel(10'd1, 10'd1);
    send_pixel(10'd511, 10'd513);
    drain();

    // pole placed on pixel (600, 300): denominator exactly zero there
    k = {CW'(176 * 32768), CW'(424 * 32768), COEF_ZERO, COEF_ZERO,
         COEF_ONE, COEF_ZERO, COEF_ONE, COEF_ZERO};
    load_coefs(k);
    send_pixel(10'd600, 10'd300);
    send_pixel(10'd601, 10'd300);
    send_pixel(10'd600, 10'd299);
    send_pixel(10'd599, 10'd301);
    drain();

    // a and c both zero: every pixel has a zero denominator
    k = {COEF_ZERO, COEF_ZERO, COEF_ONE, COEF_ONE, COEF_ZERO, COEF_ZERO,
         COEF_ONE, COEF_ONE};
    load_coefs(k);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd777, 10'd123);
    drain();

    // most negative and most positive coefficients
    k = {8{32'h8000_0000}};
    load_coefs(k);
    send_pixel(10'd0, 10'd1023);
    send_pixel(10'd1023, 10'd0);
    send_pixel(10'd300, 10'd700);
    drain();
    k = {8{32'h7fff_ffff}};
    load_coefs(k);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd700, 10'd300);
    drain();

    // random part: mostly near-identity warps, some wild sets, one burst with no gaps
    for (int ph = 0; ph < 10; ph++) begin
      if (ph % 4 == 3) k = wild_coefs();
      else k = warp_coefs();
      load_coefs(k);
      idle_on = (ph != 5);
      for (int n = 0; n < 45; n++)
        send_pixel(FW'($urandom), FW'($urandom));
      drain();
    end
    idle_on = 1'b1;

    // back to identity at the end
    k = {COEF_ONE, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO,
         COEF_ONE, COEF_ZERO};
    load_coefs(k);
    for (int n = 0; n < 10; n++)
      send_pixel(FW'($urandom), FW'($urandom));
    drain();

    $display("remap run: %0d pixel words over %0d coefficient sets", words_sent, coef_sets);
    $display("covered identity, pole on a pixel, zero denominator, extreme and random warps");
    if (fails == 0 && pending == 0) begin
      $display("[mobius_inverse_remap] OK");
    end else begin
      $display("[mobius_inverse_remap] ERROR");
    end
    $finish;
  end

endmodule
